// File: rtl/core/ookpwd_pkg.sv
package ookpwd_pkg;

    localparam int FRAME_BITS = 64;
    localparam int TIME_BITS  = 32;
    localparam int FRAME_OUT_BITS = 64;
    localparam int EDGE_BITS  = 32;
    localparam int US_BITS    = 16;
    localparam int GLITCH_BITS = 10;
    localparam int CFG_IDX_BITS = 3;
    localparam int WIN_BITS   = TIME_BITS + 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    localparam logic [US_BITS-1:0]     RST_START_HIGH = 16'd275;
    localparam logic [US_BITS-1:0]     RST_START_LOW  = 16'd2675;
    localparam logic [US_BITS-1:0]     RST_SHORT      = 16'd260;
    localparam logic [US_BITS-1:0]     RST_LONG       = 16'd1300;
    localparam logic [US_BITS-1:0]     RST_END_HIGH   = 16'd275;
    localparam logic [US_BITS-1:0]     RST_END_GAP    = 16'd9900;
    localparam logic [GLITCH_BITS-1:0] RST_GLITCH     = 10'd50;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_HIGH = 3'd0,
        CFG_START_LOW  = 3'd1,
        CFG_SHORT      = 3'd2,
        CFG_LONG       = 3'd3,
        CFG_END_HIGH   = 3'd4,
        CFG_END_GAP    = 3'd5,
        CFG_GLITCH     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [US_BITS-1:0]     start_high;
        logic [US_BITS-1:0]     start_low;
        logic [US_BITS-1:0]     short_pulse;
        logic [US_BITS-1:0]     long_pulse;
        logic [US_BITS-1:0]     end_high;
        logic [US_BITS-1:0]     end_gap;
        logic [GLITCH_BITS-1:0] glitch_min;
    } t_cfg;

    // Window results for one pulse against every nominal length.
    typedef struct packed {
        logic start_high_in;
        logic start_low_in;
        logic short_ex;
        logic long_ex;
        logic end_high_ex;
        logic end_gap_ex;
    } t_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Window from 5v/6 to 6v/5 of the nominal, done exactly as 6d against 5v and 5d against 6v.
    function automatic logic win_test(input logic [TIME_BITS-1:0] d,
                                      input logic [US_BITS-1:0] v,
                                      input logic incl);
        logic [WIN_BITS-1:0] dw;
        logic [WIN_BITS-1:0] vw;
        logic [WIN_BITS-1:0] d6;
        logic [WIN_BITS-1:0] d5;
        logic [WIN_BITS-1:0] v6;
        logic [WIN_BITS-1:0] v5;
        dw = WIN_BITS'(d);
        vw = WIN_BITS'(v);
        d6 = (dw << 2) + (dw << 1);
        d5 = (dw << 2) + dw;
        v6 = (vw << 2) + (vw << 1);
        v5 = (vw << 2) + vw;
        if (incl) begin
            return (d6 >= v5) && (d5 <= v6);
        end
        return (d6 > v5) && (d5 < v6);
    endfunction

endpackage

// File: rtl/core/ookpwd_front.sv
module ookpwd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [ookpwd_pkg::EDGE_BITS-1:0]    i_edge_time,
    input  ookpwd_pkg::t_cfg                    i_cfg,
    input  ookpwd_pkg::t_q_stat                 i_q_stat,
    output logic                                o_push,
    output ookpwd_pkg::t_flags                  o_flags
);

    logic [ookpwd_pkg::TIME_BITS-1:0] r_last;
    logic [ookpwd_pkg::TIME_BITS-1:0] n_last;
    logic [ookpwd_pkg::TIME_BITS-1:0] r_dur;
    logic [ookpwd_pkg::TIME_BITS-1:0] n_dur;
    logic                             r_dur_valid;
    logic                             n_dur_valid;
    logic [ookpwd_pkg::TIME_BITS-1:0] now;
    logic [ookpwd_pkg::TIME_BITS-1:0] dur;
    logic                             accept;
    logic                             pass;

    assign o_stall = r_dur_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign now     = i_edge_time[ookpwd_pkg::TIME_BITS-1:0];
    assign dur     = now - r_last;
    assign pass    = dur >= ookpwd_pkg::TIME_BITS'(i_cfg.glitch_min);
    assign o_push  = r_dur_valid && !i_q_stat.full;

    always_comb begin
        n_last      = r_last;
        n_dur       = r_dur;
        n_dur_valid = r_dur_valid && i_q_stat.full;
        // Glitches are dropped here and never reach the queue.
        if (accept && pass) begin
            n_last      = now;
            n_dur       = dur;
            n_dur_valid = 1'b1;
        end
    end

    always_comb begin
        o_flags.start_high_in = ookpwd_pkg::win_test(r_dur, i_cfg.start_high, 1'b1);
        o_flags.start_low_in  = ookpwd_pkg::win_test(r_dur, i_cfg.start_low, 1'b1);
        o_flags.short_ex      = ookpwd_pkg::win_test(r_dur, i_cfg.short_pulse, 1'b0);
        o_flags.long_ex       = ookpwd_pkg::win_test(r_dur, i_cfg.long_pulse, 1'b0);
        o_flags.end_high_ex   = ookpwd_pkg::win_test(r_dur, i_cfg.end_high, 1'b0);
        o_flags.end_gap_ex    = ookpwd_pkg::win_test(r_dur, i_cfg.end_gap, 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_dur_valid <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_dur_valid <= n_dur_valid;
        end
        r_dur <= n_dur;
    end

endmodule

// File: rtl/core/ookpwd_fifo.sv
module ookpwd_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ookpwd_pkg::t_flags    i_data,
    input  logic                  i_pop,
    output ookpwd_pkg::t_flags    o_data,
    output ookpwd_pkg::t_q_stat   o_stat
);

    ookpwd_pkg::t_flags                r_mem [ookpwd_pkg::QDEPTH];
    logic [ookpwd_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [ookpwd_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [ookpwd_pkg::QCNT_BITS-1:0]  r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == ookpwd_pkg::QCNT_BITS'(ookpwd_pkg::QDEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/ookpwd_back.sv
module ookpwd_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ookpwd_pkg::t_flags                    i_flags,
    input  ookpwd_pkg::t_q_stat                   i_q_stat,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [ookpwd_pkg::FRAME_OUT_BITS-1:0] o_frame
);

    logic                              r_hunt;
    logic                              n_hunt;
    logic                              r_zero_alive;
    logic                              n_zero_alive;
    logic                              r_one_alive;
    logic                              n_one_alive;
    logic                              r_end_alive;
    logic                              n_end_alive;
    logic [1:0]                        r_pos;
    logic [1:0]                        n_pos;
    logic [ookpwd_pkg::FRAME_BITS-1:0] r_shift;
    logic [ookpwd_pkg::FRAME_BITS-1:0] n_shift;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [ookpwd_pkg::FRAME_BITS-1:0] r_out_frame;
    logic [ookpwd_pkg::FRAME_BITS-1:0] n_out_frame;
    logic                              zero_hit;
    logic                              one_hit;
    logic                              end_hit;
    logic                              done;

    // The output register is the only buffer on the result side, so a new
    // transaction is taken whenever that register is free or being drained.
    assign o_pop   = !i_q_stat.empty && !(r_out_valid && i_stall);
    assign o_valid = r_out_valid;
    assign o_frame = ookpwd_pkg::FRAME_OUT_BITS'(r_out_frame);

    always_comb begin
        n_hunt       = r_hunt;
        n_zero_alive = r_zero_alive;
        n_one_alive  = r_one_alive;
        n_end_alive  = r_end_alive;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_out_frame  = r_out_frame;
        n_out_valid  = r_out_valid && i_stall;
        done         = 1'b0;
        zero_hit     = (r_pos == 2'd3) ? i_flags.long_ex : i_flags.short_ex;
        one_hit      = (r_pos == 2'd1) ? i_flags.long_ex : i_flags.short_ex;
        end_hit      = (r_pos == 2'd0) ? i_flags.end_high_ex
                     : ((r_pos == 2'd1) && i_flags.end_gap_ex);

        if (o_pop) begin
            if (r_hunt) begin
                if (!((r_pos == 2'd0) ? i_flags.start_high_in : i_flags.start_low_in)) begin
                    n_pos = 2'd0;
                end else if (r_pos != 2'd0) begin
                    n_pos        = 2'd0;
                    n_shift      = '0;
                    n_hunt       = 1'b0;
                    n_zero_alive = 1'b1;
                    n_one_alive  = 1'b1;
                    n_end_alive  = 1'b1;
                end else begin
                    n_pos = 2'd1;
                end
            end else begin
                if (r_zero_alive) begin
                    if (!zero_hit) begin
                        n_zero_alive = 1'b0;
                    end else if (r_pos == 2'd3) begin
                        done        = 1'b1;
                        n_pos       = 2'd0;
                        n_one_alive = 1'b1;
                        n_end_alive = 1'b1;
                        n_shift     = r_shift << 1;
                    end
                end
                if (!done && r_one_alive) begin
                    if (!one_hit) begin
                        n_one_alive = 1'b0;
                    end else if (r_pos == 2'd3) begin
                        done         = 1'b1;
                        n_pos        = 2'd0;
                        n_zero_alive = 1'b1;
                        n_end_alive  = 1'b1;
                        n_shift      = {r_shift[ookpwd_pkg::FRAME_BITS-2:0], 1'b1};
                    end
                end
                if (!done && r_end_alive) begin
                    if (!end_hit) begin
                        n_end_alive = 1'b0;
                    end else if (r_pos == 2'd1) begin
                        done        = 1'b1;
                        n_pos       = 2'd0;
                        n_hunt      = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_frame = r_shift;
                    end
                end
                if (!done) begin
                    n_pos = r_pos + 2'd1;
                    if (!(n_zero_alive || n_one_alive || n_end_alive)) begin
                        n_pos  = 2'd0;
                        n_hunt = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunt       <= 1'b1;
            r_zero_alive <= 1'b0;
            r_one_alive  <= 1'b0;
            r_end_alive  <= 1'b0;
            r_pos        <= 2'd0;
            r_shift      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_hunt       <= n_hunt;
            r_zero_alive <= n_zero_alive;
            r_one_alive  <= n_one_alive;
            r_end_alive  <= n_end_alive;
            r_pos        <= n_pos;
            r_shift      <= n_shift;
            r_out_valid  <= n_out_valid;
        end
        r_out_frame <= n_out_frame;
    end

endmodule

// File: rtl/core/ook_pulse_width_frame_decoder_top.sv
// Path: the edge that closes a frame's end latch loads the duration register,
// then the queue and then the output register, which presents the frame; a
// full queue or a stalled output can hold the transaction between these
// registers.
// Throughput: one edge per cycle while o_stall is low.
// Reset is synchronous and active low; it restores the default timings and
// returns the decoder to hunting for a start latch.
module ook_pulse_width_frame_decoder_top (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [ookpwd_pkg::EDGE_BITS-1:0]           i_edge_time,
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic [ookpwd_pkg::FRAME_OUT_BITS-1:0]      o_frame,
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [ookpwd_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [ookpwd_pkg::US_BITS-1:0]             i_cfg_data
);

    ookpwd_pkg::t_cfg     r_cfg;
    ookpwd_pkg::t_cfg     n_cfg;
    ookpwd_pkg::t_q_stat  q_stat;
    ookpwd_pkg::t_flags   push_flags;
    ookpwd_pkg::t_flags   pop_flags;
    logic                 push;
    logic                 pop;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (ookpwd_pkg::t_cfg_idx'(i_cfg_index))
                ookpwd_pkg::CFG_START_HIGH: n_cfg.start_high  = i_cfg_data;
                ookpwd_pkg::CFG_START_LOW:  n_cfg.start_low   = i_cfg_data;
                ookpwd_pkg::CFG_SHORT:      n_cfg.short_pulse = i_cfg_data;
                ookpwd_pkg::CFG_LONG:       n_cfg.long_pulse  = i_cfg_data;
                ookpwd_pkg::CFG_END_HIGH:   n_cfg.end_high    = i_cfg_data;
                ookpwd_pkg::CFG_END_GAP:    n_cfg.end_gap     = i_cfg_data;
                ookpwd_pkg::CFG_GLITCH:
                    n_cfg.glitch_min = i_cfg_data[ookpwd_pkg::GLITCH_BITS-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_high  <= ookpwd_pkg::RST_START_HIGH;
            r_cfg.start_low   <= ookpwd_pkg::RST_START_LOW;
            r_cfg.short_pulse <= ookpwd_pkg::RST_SHORT;
            r_cfg.long_pulse  <= ookpwd_pkg::RST_LONG;
            r_cfg.end_high    <= ookpwd_pkg::RST_END_HIGH;
            r_cfg.end_gap     <= ookpwd_pkg::RST_END_GAP;
            r_cfg.glitch_min  <= ookpwd_pkg::RST_GLITCH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    ookpwd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_edge_time (i_edge_time),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_flags     (push_flags)
    );

    ookpwd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_flags),
        .i_pop   (pop),
        .o_data  (pop_flags),
        .o_stat  (q_stat)
    );

    ookpwd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flags  (pop_flags),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_frame  (o_frame)
    );

    a_queue_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pattern engine popped an empty queue");

    a_frame_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(pop))
        else $error("frame appeared without a queue transaction");

endmodule
